@@ rtl/core/rar_pkg.sv @@
// Shared types, constants and the microcode table of the rational accumulator.
// Depends on nothing; imported by rational_accumulator_reduce.
package rar_pkg;

    // Datapath widths
    localparam int OPERAND_WIDTH = 16;
    localparam int STATE_WIDTH   = 32;
    localparam int IN_FIELD_W    = 16;
    localparam int OUT_FIELD_W   = 32;
    // Sum of two cross products needs one bit above the product width
    localparam int PROD_W        = STATE_WIDTH + OPERAND_WIDTH;
    localparam int WORK_W        = PROD_W + 1;
    localparam int CNT_W         = $clog2(WORK_W);

    // Item kinds carried in the request tuser
    localparam logic [1:0] MODE_LOAD   = 2'd0;
    localparam logic [1:0] MODE_ADD    = 2'd1;
    localparam logic [1:0] MODE_MUL    = 2'd2;
    localparam logic [1:0] MODE_UNUSED = 2'd3;

    // Result status codes
    localparam logic [1:0] STATUS_OK       = 2'd0;
    localparam logic [1:0] STATUS_ZERO_DEN = 2'd1;
    localparam logic [1:0] STATUS_OVERFLOW = 2'd2;

    // Micro-operations applied to the datapath
    typedef enum logic [4:0] {
        U_NOP,
        U_ACCEPT,
        U_MUL_NUM,
        U_MUL_DEN,
        U_MUL_CROSS,
        U_ADD,
        U_LOAD,
        U_ZERO,
        U_GCD_INIT,
        U_HALVE_BOTH,
        U_HALVE_A,
        U_HALVE_B,
        U_SUBTRACT,
        U_DOUBLE_A,
        U_DIV_INIT,
        U_DIV_STEP,
        U_COMMIT,
        U_EMIT
    } t_uop;

    // Jump conditions; a false condition falls through to the next step
    typedef enum logic [3:0] {
        C_NEVER,
        C_ALWAYS,
        C_NO_INPUT,
        C_MODE_UNUSED,
        C_DEN_ZERO,
        C_MODE_LOAD,
        C_MODE_MUL,
        C_NUM_ZERO,
        C_BOTH_EVEN,
        C_A_EVEN,
        C_B_ZERO,
        C_B_EVEN,
        C_K_NONZERO,
        C_CNT_NONZERO,
        C_OVERFLOW,
        C_OUT_BUSY
    } t_cond;

    localparam int PC_W = 5;
    typedef logic [PC_W-1:0] t_pc;

    // Program labels
    localparam t_pc L_WAIT     = t_pc'(0);
    localparam t_pc L_LOAD     = t_pc'(8);
    localparam t_pc L_REDUCE   = t_pc'(9);
    localparam t_pc L_TWOS     = t_pc'(11);
    localparam t_pc L_ODD_A    = t_pc'(12);
    localparam t_pc L_LOOP     = t_pc'(13);
    localparam t_pc L_ODD_B    = t_pc'(14);
    localparam t_pc L_RESTORE  = t_pc'(16);
    localparam t_pc L_DIV      = t_pc'(18);
    localparam t_pc L_COMMIT   = t_pc'(20);
    localparam t_pc L_ZERO     = t_pc'(21);
    localparam t_pc L_DONE     = t_pc'(22);
    localparam t_pc L_REJECT   = t_pc'(24);
    localparam t_pc L_OVERFLOW = t_pc'(26);

    // One control word per step
    typedef struct packed {
        t_uop       uop;
        t_cond      cond;
        t_pc        target;
        logic [1:0] status;
    } t_ctrl;

    // Microcode read-only table
    function automatic t_ctrl f_ucode(input t_pc pc);
        t_ctrl w;
        w = '{uop: U_NOP, cond: C_ALWAYS, target: L_WAIT, status: STATUS_OK};
        unique case (pc)
            t_pc'(0):  w = '{U_ACCEPT,     C_NO_INPUT,    L_WAIT,     STATUS_OK};
            t_pc'(1):  w = '{U_NOP,        C_MODE_UNUSED, L_DONE,     STATUS_OK};
            t_pc'(2):  w = '{U_NOP,        C_DEN_ZERO,    L_REJECT,   STATUS_OK};
            t_pc'(3):  w = '{U_NOP,        C_MODE_LOAD,   L_LOAD,     STATUS_OK};
            t_pc'(4):  w = '{U_MUL_NUM,    C_NEVER,       L_WAIT,     STATUS_OK};
            t_pc'(5):  w = '{U_MUL_DEN,    C_MODE_MUL,    L_REDUCE,   STATUS_OK};
            t_pc'(6):  w = '{U_MUL_CROSS,  C_NEVER,       L_WAIT,     STATUS_OK};
            t_pc'(7):  w = '{U_ADD,        C_ALWAYS,      L_REDUCE,   STATUS_OK};
            t_pc'(8):  w = '{U_LOAD,       C_NEVER,       L_WAIT,     STATUS_OK};
            t_pc'(9):  w = '{U_NOP,        C_NUM_ZERO,    L_ZERO,     STATUS_OK};
            t_pc'(10): w = '{U_GCD_INIT,   C_NEVER,       L_WAIT,     STATUS_OK};
            t_pc'(11): w = '{U_HALVE_BOTH, C_BOTH_EVEN,   L_TWOS,     STATUS_OK};
            t_pc'(12): w = '{U_HALVE_A,    C_A_EVEN,      L_ODD_A,    STATUS_OK};
            t_pc'(13): w = '{U_NOP,        C_B_ZERO,      L_RESTORE,  STATUS_OK};
            t_pc'(14): w = '{U_HALVE_B,    C_B_EVEN,      L_ODD_B,    STATUS_OK};
            t_pc'(15): w = '{U_SUBTRACT,   C_ALWAYS,      L_LOOP,     STATUS_OK};
            t_pc'(16): w = '{U_DOUBLE_A,   C_K_NONZERO,   L_RESTORE,  STATUS_OK};
            t_pc'(17): w = '{U_DIV_INIT,   C_NEVER,       L_WAIT,     STATUS_OK};
            t_pc'(18): w = '{U_DIV_STEP,   C_CNT_NONZERO, L_DIV,      STATUS_OK};
            t_pc'(19): w = '{U_NOP,        C_OVERFLOW,    L_OVERFLOW, STATUS_OK};
            t_pc'(20): w = '{U_COMMIT,     C_ALWAYS,      L_DONE,     STATUS_OK};
            t_pc'(21): w = '{U_ZERO,       C_ALWAYS,      L_COMMIT,   STATUS_OK};
            t_pc'(22): w = '{U_NOP,        C_OUT_BUSY,    L_DONE,     STATUS_OK};
            t_pc'(23): w = '{U_EMIT,       C_ALWAYS,      L_WAIT,     STATUS_OK};
            t_pc'(24): w = '{U_NOP,        C_OUT_BUSY,    L_REJECT,   STATUS_OK};
            t_pc'(25): w = '{U_EMIT,       C_ALWAYS,      L_WAIT,     STATUS_ZERO_DEN};
            t_pc'(26): w = '{U_NOP,        C_OUT_BUSY,    L_OVERFLOW, STATUS_OK};
            t_pc'(27): w = '{U_EMIT,       C_ALWAYS,      L_WAIT,     STATUS_OVERFLOW};
            default:   w = '{U_NOP,        C_ALWAYS,      L_WAIT,     STATUS_OK};
        endcase
        return w;
    endfunction

endpackage

@@ rtl/core/rational_accumulator_reduce.sv @@
// Rational accumulator with GCD reduction, driven by a microcoded sequencer.
// Depends on rar_pkg for widths, codes and the microcode table.
//
// Usage: each request on the slave stream carries a fraction in tdata and a
// mode in tuser (load, add, multiply). The block updates its non-negative
// accumulator num/den, reduces it by the GCD and returns one result per
// request on the master stream: the accumulator after the request and a status
// (ok, zero denominator rejected, overflow with state kept).
// One request is worked on at a time; tready is high only while the sequencer
// sits at its wait step. Add and multiply requests run the multiplies, then
// the binary GCD loop of halving and subtract passes and the combined
// two-quotient restoring division (WORK_W = 49 steps); load requests skip
// the multiplies. Rejected and unused-mode requests skip the arithmetic.
// The result waits in an output register; the next request is accepted while
// the receiver stalls, and the block only holds before writing a new result.
// Reset sets the accumulator to 0/1, empties the output and returns the
// sequencer to its wait step.
module rational_accumulator_reduce
    import rar_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Request stream
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [31:0] i_s_axis_tdata,  // [15:0] operand_numerator, [31:16] operand_denominator
    input  logic [1:0]  i_s_axis_tuser,  // [1:0] mode
    // Result stream
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [63:0] o_m_axis_tdata,  // [31:0] result_numerator, [63:32] result_denominator
    output logic [1:0]  o_m_axis_tuser   // [1:0] status
);

    // Sequencer and architectural state
    t_pc                      r_pc;
    logic [STATE_WIDTH-1:0]   r_acc_num;
    logic [STATE_WIDTH-1:0]   r_acc_den;

    // Latched request
    logic [1:0]               r_mode;
    logic [OPERAND_WIDTH-1:0] r_on;
    logic [OPERAND_WIDTH-1:0] r_od;

    // Working registers
    logic [WORK_W-1:0]        r_num;
    logic [WORK_W-1:0]        r_den;
    logic [WORK_W-1:0]        r_a;
    logic [WORK_W-1:0]        r_b;
    logic [WORK_W-1:0]        r_rem_n;
    logic [WORK_W-1:0]        r_rem_d;
    logic [CNT_W-1:0]         r_k;
    logic [CNT_W-1:0]         r_cnt;

    // Result register
    logic                     r_out_valid;
    logic [OUT_FIELD_W-1:0]   r_out_num;
    logic [OUT_FIELD_W-1:0]   r_out_den;
    logic [1:0]               r_out_status;

    t_ctrl                    w_ctrl;
    t_pc                      n_pc;
    logic                     w_jump;
    logic                     w_accept;
    logic [STATE_WIDTH-1:0]   w_mx;
    logic [OPERAND_WIDTH-1:0] w_my;
    logic [PROD_W-1:0]        w_prod;
    logic                     w_a_gt_b;
    logic [WORK_W-1:0]        w_a_minus_b;
    logic [WORK_W-1:0]        w_b_minus_a;
    logic [WORK_W:0]          w_shift_n;
    logic [WORK_W:0]          w_shift_d;
    logic [WORK_W:0]          w_diff_n;
    logic [WORK_W:0]          w_diff_d;
    logic                     w_qbit_n;
    logic                     w_qbit_d;
    logic                     w_overflow;

    // Current control word
    assign w_ctrl   = f_ucode(r_pc);
    assign w_accept = i_s_axis_tvalid && o_s_axis_tready;

    assign o_s_axis_tready = (w_ctrl.uop == U_ACCEPT);
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {r_out_den, r_out_num};
    assign o_m_axis_tuser  = r_out_status;

    // Overflow when a reduced value needs more than the state width
    assign w_overflow = (|r_num[WORK_W-1:STATE_WIDTH]) || (|r_den[WORK_W-1:STATE_WIDTH]);

    // Jump condition evaluation
    always_comb begin
        unique case (w_ctrl.cond)
            C_NEVER:       w_jump = 1'b0;
            C_ALWAYS:      w_jump = 1'b1;
            C_NO_INPUT:    w_jump = !i_s_axis_tvalid;
            C_MODE_UNUSED: w_jump = (r_mode == MODE_UNUSED);
            C_DEN_ZERO:    w_jump = (r_od == '0);
            C_MODE_LOAD:   w_jump = (r_mode == MODE_LOAD);
            C_MODE_MUL:    w_jump = (r_mode == MODE_MUL);
            C_NUM_ZERO:    w_jump = (r_num == '0);
            C_BOTH_EVEN:   w_jump = !r_a[0] && !r_b[0];
            C_A_EVEN:      w_jump = !r_a[0];
            C_B_ZERO:      w_jump = (r_b == '0);
            C_B_EVEN:      w_jump = !r_b[0];
            C_K_NONZERO:   w_jump = (r_k != '0);
            C_CNT_NONZERO: w_jump = (r_cnt != '0);
            C_OVERFLOW:    w_jump = w_overflow;
            C_OUT_BUSY:    w_jump = r_out_valid;
        endcase
        n_pc = w_jump ? w_ctrl.target : t_pc'(r_pc + 1'b1);
    end

    // Shared multiplier operand selection
    always_comb begin
        unique case (w_ctrl.uop)
            U_MUL_NUM: begin
                w_mx = r_acc_num;
                w_my = (r_mode == MODE_ADD) ? r_od : r_on;
            end
            U_MUL_DEN: begin
                w_mx = r_acc_den;
                w_my = r_od;
            end
            U_MUL_CROSS: begin
                w_mx = r_acc_den;
                w_my = r_on;
            end
            default: begin
                w_mx = r_acc_num;
                w_my = r_on;
            end
        endcase
    end

    assign w_prod = PROD_W'(w_mx) * PROD_W'(w_my);

    // Binary GCD subtract step
    assign w_a_gt_b    = (r_a > r_b);
    assign w_a_minus_b = r_a - r_b;
    assign w_b_minus_a = r_b - r_a;

    // Restoring division of numerator and denominator by the same divisor
    assign w_shift_n = {r_rem_n, r_num[WORK_W-1]};
    assign w_shift_d = {r_rem_d, r_den[WORK_W-1]};
    assign w_diff_n  = w_shift_n - {1'b0, r_a};
    assign w_diff_d  = w_shift_d - {1'b0, r_a};
    assign w_qbit_n  = (w_shift_n >= {1'b0, r_a});
    assign w_qbit_d  = (w_shift_d >= {1'b0, r_a});

    // Sequencer, datapath and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc        <= L_WAIT;
            r_acc_num   <= '0;
            r_acc_den   <= STATE_WIDTH'(1);
            r_out_valid <= 1'b0;
        end else begin
            r_pc <= n_pc;
            if (r_out_valid && i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
            unique case (w_ctrl.uop)
                U_NOP: begin
                end
                U_ACCEPT: begin
                    if (w_accept) begin
                        r_mode <= i_s_axis_tuser;
                        r_on   <= OPERAND_WIDTH'(i_s_axis_tdata[IN_FIELD_W-1:0]);
                        r_od   <= OPERAND_WIDTH'(i_s_axis_tdata[2*IN_FIELD_W-1:IN_FIELD_W]);
                    end
                end
                U_MUL_NUM:   r_num <= WORK_W'(w_prod);
                U_MUL_DEN:   r_den <= WORK_W'(w_prod);
                U_MUL_CROSS: r_b   <= WORK_W'(w_prod);
                U_ADD:       r_num <= r_num + r_b;
                U_LOAD: begin
                    r_num <= WORK_W'(r_on);
                    r_den <= WORK_W'(r_od);
                end
                U_ZERO: begin
                    r_num <= '0;
                    r_den <= WORK_W'(1);
                end
                U_GCD_INIT: begin
                    r_a <= r_num;
                    r_b <= r_den;
                    r_k <= '0;
                end
                U_HALVE_BOTH: begin
                    if (!r_a[0] && !r_b[0]) begin
                        r_a <= r_a >> 1;
                        r_b <= r_b >> 1;
                        r_k <= r_k + 1'b1;
                    end
                end
                U_HALVE_A: begin
                    if (!r_a[0]) begin
                        r_a <= r_a >> 1;
                    end
                end
                U_HALVE_B: begin
                    if (!r_b[0]) begin
                        r_b <= r_b >> 1;
                    end
                end
                U_SUBTRACT: begin
                    if (w_a_gt_b) begin
                        r_a <= r_b;
                        r_b <= w_a_minus_b;
                    end else begin
                        r_b <= w_b_minus_a;
                    end
                end
                U_DOUBLE_A: begin
                    if (r_k != '0) begin
                        r_a <= r_a << 1;
                        r_k <= r_k - 1'b1;
                    end
                end
                U_DIV_INIT: begin
                    r_rem_n <= '0;
                    r_rem_d <= '0;
                    r_cnt   <= CNT_W'(WORK_W - 1);
                end
                U_DIV_STEP: begin
                    r_rem_n <= w_qbit_n ? w_diff_n[WORK_W-1:0] : w_shift_n[WORK_W-1:0];
                    r_rem_d <= w_qbit_d ? w_diff_d[WORK_W-1:0] : w_shift_d[WORK_W-1:0];
                    r_num   <= {r_num[WORK_W-2:0], w_qbit_n};
                    r_den   <= {r_den[WORK_W-2:0], w_qbit_d};
                    r_cnt   <= r_cnt - 1'b1;
                end
                U_COMMIT: begin
                    r_acc_num <= r_num[STATE_WIDTH-1:0];
                    r_acc_den <= r_den[STATE_WIDTH-1:0];
                end
                U_EMIT: begin
                    r_out_valid  <= 1'b1;
                    r_out_num    <= OUT_FIELD_W'(r_acc_num);
                    r_out_den    <= OUT_FIELD_W'(r_acc_den);
                    r_out_status <= w_ctrl.status;
                end
            endcase
        end
    end

    // A new result is only written into an empty output register
    a_emit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_ctrl.uop == U_EMIT) |-> !r_out_valid)
        else $error("result written over a pending result");

    // A result appears only after an emit step
    a_valid_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(w_ctrl.uop == U_EMIT))
        else $error("output valid without an emit step");

    // The accumulator denominator never becomes zero
    a_den_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_acc_den != '0))
        else $error("accumulator denominator is zero");

    // The division always runs with a nonzero GCD as divisor
    a_divisor_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_ctrl.uop == U_DIV_STEP) |-> (r_a != '0))
        else $error("division by a zero divisor");

endmodule
